// File: sv/ertt_pkg.sv
// Shared types and constants of the epoch RMS threshold trigger.
// Used by ertt_alu and epoch_rms_threshold_trigger; depends on nothing.
`default_nettype none

package ertt_pkg;

  localparam int DECIM_DEFAULT       = 2;
  localparam int COUNT_WIDTH_DEFAULT = 24;

  localparam int CHAN_W   = 10;
  localparam int SAMPLE_W = 16;
  localparam int EPOCH_W  = 16;
  localparam int RMS_W    = 20;
  localparam int LINE_W   = 5;
  localparam int CFG_W    = 20;
  localparam int CFG_IDX_W = 2;

  localparam int SUM_W   = 56;
  localparam int FRAC_SH = 8;
  localparam int DVD_W   = SUM_W + FRAC_SH;
  localparam int ROOT_IN_W = 2 * RMS_W;
  localparam int ALU_W   = SUM_W;

  localparam logic [EPOCH_W-1:0]  EPOCH_MS_RESET = 16'd1000;
  localparam logic [SAMPLE_W-1:0] MIDSCALE       = 16'h8000;

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_TICK   = 2'd1,
    FUNC_START  = 2'd2,
    FUNC_STOP   = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SELECTED_CHANNEL = 2'd0,
    REG_EPOCH_MS         = 2'd1,
    REG_RMS_THRESHOLD_Q4 = 2'd2,
    REG_TRIGGER_SOURCE   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    func_e               func;
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] sample;
    logic                batch_start;
  } in_t;

  typedef struct packed {
    logic [RMS_W-1:0]  rms_q4;
    logic              stimulate;
    logic [LINE_W-1:0] stim_line;
    logic              epoch_empty;
  } out_t;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             flag;
  } alu_rsp_t;

endpackage

`default_nettype wire

// File: sv/ertt_alu.sv
// Shared add and subtract unit of the epoch RMS threshold trigger.
// Depends on ertt_pkg. The flag is the carry of an add or the borrow of a subtract.
`default_nettype none

module ertt_alu
  import ertt_pkg::*;
(
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [ALU_W:0] full;

  always_comb begin
    if (req_i.sub) begin
      full = {1'b0, req_i.a} - {1'b0, req_i.b};
    end else begin
      full = {1'b0, req_i.a} + {1'b0, req_i.b};
    end
    rsp_o.res  = full[ALU_W-1:0];
    rsp_o.flag = full[ALU_W];
  end

endmodule

`default_nettype wire

// File: sv/epoch_rms_threshold_trigger.sv
// Top level of the epoch RMS threshold trigger: sequencer, accumulator, divider and root.
// Depends on ertt_pkg and ertt_alu.
//
//   channel  signals                              payload  transfer when
//   input    in_valid_i / in_ready_o              in_t     valid and ready high
//   output   out_valid_o / out_ready_i            out_t    valid and ready high
//   config   cfg_we_i, cfg_idx_i, cfg_wdata_i     20 bits  write enable high
//
// Start, stop, ticks within an epoch and unused samples are handled at accept alone.
// An accumulated sample is accepted, squared, then added in the shared unit.
// An epoch end runs accept, 64 divider and 20 root steps in the shared unit,
// and the load of the output register; an overflowing quotient skips the root steps,
// and an empty epoch goes from accept straight to the load.
// The load waits while the output register holds an earlier result, and the input stays
// stalled meanwhile. Reset clears control and epoch state, and resets the configuration.
`default_nettype none

module epoch_rms_threshold_trigger
  import ertt_pkg::*;
#(
  parameter int DECIM       = DECIM_DEFAULT,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int PHASE_W = (DECIM > 1) ? $clog2(DECIM) : 1;
  localparam logic [PHASE_W:0] DECIM_V = (PHASE_W + 1)'(DECIM);
  localparam int STEP_W = $clog2(DVD_W);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DVD_W - 1);
  localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(RMS_W - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_DIV,
    S_ROOT,
    S_DONE
  } state_e;

  state_e                 state_q, state_d;
  logic                   running_q, running_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [EPOCH_W-1:0]     tick_q, tick_d;
  logic [PHASE_W-1:0]     phase_q, phase_d;
  logic [STEP_W-1:0]      step_q, step_d;
  logic                   out_valid_q, out_valid_d;
  out_t                   out_q, out_d;

  logic [CHAN_W-1:0]  sel_chan_q;
  logic [EPOCH_W-1:0] epoch_ms_q;
  logic [RMS_W-1:0]   thr_q;
  logic [LINE_W-1:0]  trig_src_q;

  logic [SAMPLE_W-1:0]    mag_q, mag_d;
  logic [2*SAMPLE_W-1:0]  sq_q, sq_d;
  logic [DVD_W-1:0]       dvd_q, dvd_d;
  logic [COUNT_WIDTH-1:0] dvs_q, dvs_d;
  logic [COUNT_WIDTH-1:0] rem_q, rem_d;
  logic [ROOT_IN_W-1:0]   quo_q, quo_d;
  logic                   ovf_q, ovf_d;
  logic [ROOT_IN_W-1:0]   val_q, val_d;
  logic [ROOT_IN_W-1:0]   root_q, root_d;
  logic [ROOT_IN_W-1:0]   bit_q, bit_d;
  logic [RMS_W-1:0]       rms_q, rms_d;
  logic                   empty_q, empty_d;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic [PHASE_W-1:0]   phase_eff;
  logic [PHASE_W:0]     phase_inc;
  logic [EPOCH_W-1:0]   tick_inc;
  logic [EPOCH_W-1:0]   epoch_len;
  logic [COUNT_WIDTH:0] rem_sh;
  logic                 qbit;
  logic                 stim;

  ertt_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign phase_eff = in_data_i.batch_start ? '0 : phase_q;
  assign phase_inc = {1'b0, phase_eff} + 1'b1;
  assign tick_inc  = tick_q + 1'b1;
  assign epoch_len = (epoch_ms_q == '0) ? EPOCH_W'(1) : epoch_ms_q;
  assign rem_sh    = {rem_q, dvd_q[DVD_W-1]};
  assign qbit      = ~alu_rsp.flag;
  assign stim      = ~empty_q && (rms_q > thr_q);

  always_comb begin
    state_d     = state_q;
    running_d   = running_q;
    sum_d       = sum_q;
    count_d     = count_q;
    tick_d      = tick_q;
    phase_d     = phase_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mag_d       = mag_q;
    sq_d        = sq_q;
    dvd_d       = dvd_q;
    dvs_d       = dvs_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    ovf_d       = ovf_q;
    val_d       = val_q;
    root_d      = root_q;
    bit_d       = bit_q;
    rms_d       = rms_q;
    empty_d     = empty_q;
    alu_req     = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.func)
            FUNC_START: begin
              if (!running_q) begin
                running_d = 1'b1;
                sum_d     = '0;
                count_d   = '0;
                tick_d    = '0;
                phase_d   = '0;
              end
            end
            FUNC_STOP: begin
              if (running_q) begin
                running_d = 1'b0;
                sum_d     = '0;
                count_d   = '0;
                tick_d    = '0;
              end
            end
            FUNC_SAMPLE: begin
              if (running_q) begin
                phase_d = phase_eff;
                if (in_data_i.channel == sel_chan_q) begin
                  phase_d = (phase_inc >= DECIM_V) ? '0 : phase_inc[PHASE_W-1:0];
                  if (phase_eff == '0 && !(&count_q)) begin
                    if (in_data_i.sample[SAMPLE_W-1]) begin
                      mag_d = in_data_i.sample - MIDSCALE;
                    end else begin
                      mag_d = MIDSCALE - in_data_i.sample;
                    end
                    state_d = S_MUL;
                  end
                end
              end
            end
            FUNC_TICK: begin
              if (running_q) begin
                if (tick_inc < epoch_len) begin
                  tick_d = tick_inc;
                end else begin
                  tick_d = '0;
                  if (count_q == '0) begin
                    rms_d   = '0;
                    empty_d = 1'b1;
                    state_d = S_DONE;
                  end else begin
                    dvd_d   = {sum_q, {FRAC_SH{1'b0}}};
                    dvs_d   = count_q;
                    rem_d   = '0;
                    quo_d   = '0;
                    ovf_d   = 1'b0;
                    step_d  = DIV_LAST;
                    empty_d = 1'b0;
                    sum_d   = '0;
                    count_d = '0;
                    state_d = S_DIV;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_MUL: begin
        sq_d    = mag_q * mag_q;
        state_d = S_ACC;
      end
      S_ACC: begin
        alu_req.a   = sum_q;
        alu_req.b   = ALU_W'(sq_q);
        alu_req.sub = 1'b0;
        sum_d       = alu_rsp.flag ? '1 : alu_rsp.res;
        count_d     = count_q + 1'b1;
        state_d     = S_IDLE;
      end
      S_DIV: begin
        alu_req.a   = ALU_W'(rem_sh);
        alu_req.b   = ALU_W'(dvs_q);
        alu_req.sub = 1'b1;
        rem_d       = qbit ? alu_rsp.res[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
        dvd_d       = {dvd_q[DVD_W-2:0], 1'b0};
        ovf_d       = ovf_q | quo_q[ROOT_IN_W-1];
        quo_d       = {quo_q[ROOT_IN_W-2:0], qbit};
        if (step_q == '0) begin
          if (ovf_d) begin
            rms_d   = '1;
            state_d = S_DONE;
          end else begin
            val_d   = quo_d;
            root_d  = '0;
            bit_d   = {2'b01, {(ROOT_IN_W - 2){1'b0}}};
            step_d  = ROOT_LAST;
            state_d = S_ROOT;
          end
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      S_ROOT: begin
        alu_req.a   = ALU_W'(val_q);
        alu_req.b   = ALU_W'(root_q | bit_q);
        alu_req.sub = 1'b1;
        if (!alu_rsp.flag) begin
          val_d  = alu_rsp.res[ROOT_IN_W-1:0];
          root_d = (root_q >> 1) | bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (step_q == '0) begin
          rms_d   = root_d[RMS_W-1:0];
          state_d = S_DONE;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_q) begin
          out_d.rms_q4      = rms_q;
          out_d.stimulate   = stim;
          out_d.stim_line   = stim ? trig_src_q : '0;
          out_d.epoch_empty = empty_q;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      running_q   <= 1'b0;
      sum_q       <= '0;
      count_q     <= '0;
      tick_q      <= '0;
      phase_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      tick_q      <= tick_d;
      phase_q     <= phase_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_chan_q <= '0;
      epoch_ms_q <= EPOCH_MS_RESET;
      thr_q      <= '0;
      trig_src_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SELECTED_CHANNEL: sel_chan_q <= cfg_wdata_i[CHAN_W-1:0];
        REG_EPOCH_MS:         epoch_ms_q <= cfg_wdata_i[EPOCH_W-1:0];
        REG_RMS_THRESHOLD_Q4: thr_q      <= cfg_wdata_i[RMS_W-1:0];
        REG_TRIGGER_SOURCE:   trig_src_q <= cfg_wdata_i[LINE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    sq_q    <= sq_d;
    dvd_q   <= dvd_d;
    dvs_q   <= dvs_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    ovf_q   <= ovf_d;
    val_q   <= val_d;
    root_q  <= root_d;
    bit_q   <= bit_d;
    rms_q   <= rms_d;
    empty_q <= empty_d;
  end

  // An empty accumulator never carries a nonzero sum.
  a_empty_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (sum_q == '0))
    else $error("sum nonzero while sample count is zero");

  // While stopped, the epoch state stays cleared.
  a_stopped_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |-> (tick_q == '0 && count_q == '0))
    else $error("epoch state not cleared while stopped");

  // An empty epoch never fires stimulation.
  a_empty_no_stim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.stimulate && out_q.epoch_empty))
    else $error("empty epoch flagged with stimulation");

  // A result is loaded only when the output register was free.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && state_d == S_IDLE) |-> !out_valid_q)
    else $error("result loaded over a pending result");

endmodule

`default_nettype wire
